[rtl/wscm_pkg.sv]
// ----------------------------------------------------------------------------
// wscm_pkg
// Shared types and constants for the weighted strip cluster moments core.
// ----------------------------------------------------------------------------
package wscm_pkg;

  localparam int DEF_MAX_CLUSTER_STRIPS = 64;
  localparam int DEF_STRIPS_PER_PLANE   = 512;

  localparam int ESUM_W = 24;
  localparam int PSUM_W = 35;
  localparam int QSUM_W = 46;
  localparam int Q98_W  = 17;
  localparam int CNT_W  = 7;

  typedef struct packed {
    logic        new_cluster;
    logic [8:0]  strip_index;
    logic [15:0] strip_energy;
    logic [15:0] strip_weight;
    logic        strip_plane;
    logic [3:0]  strip_sector;
  } in_t;

  typedef struct packed {
    logic [23:0] cluster_energy;
    logic [16:0] centroid;
    logic [16:0] rms_width;
    logic [6:0]  strips_in_cluster;
    logic        seed_plane;
    logic [3:0]  seed_sector;
    logic        zero_energy;
    logic        overflow;
  } out_t;

  // Snapshot of the cluster sums after one strip.
  typedef struct packed {
    logic [ESUM_W-1:0] esum;
    logic [PSUM_W-1:0] psum;
    logic [QSUM_W-1:0] qsum;
    logic [CNT_W-1:0]  count;
    logic              plane;
    logic [3:0]        sector;
    logic              ovf;
  } snap_t;

  // Queue status handed to the two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/weighted_strip_cluster_moments_core.sv]
// ----------------------------------------------------------------------------
// weighted_strip_cluster_moments_core
// Energy weighted centroid and RMS width of a strip cluster.
// ----------------------------------------------------------------------------
//  channel | ports                            | transaction
//  input   | in_valid, in_ready, in_data      | one strip
//  output  | out_valid, out_ready, out_data   | cluster moments after that strip
//
//  A strip passes the front steps multiply, round, moment products and
//  saturating accumulate; a new strip is taken only after the last is
//  accumulated and the queue is not full. The back runs 3 x 60 divider
//  steps, 50 multiply steps and the root steps per result; the shared
//  bit-serial divider sets the sustained rate. A zero energy sum skips
//  straight to the result. Reset (rst_n low, synchronous) clears the sums,
//  the queue and both FSMs. A stalled output holds its register; the front
//  keeps filling the two-entry queue until it is full.
// ----------------------------------------------------------------------------
module weighted_strip_cluster_moments_core #(
  parameter int MAX_CLUSTER_STRIPS = wscm_pkg::DEF_MAX_CLUSTER_STRIPS,
  parameter int STRIPS_PER_PLANE   = wscm_pkg::DEF_STRIPS_PER_PLANE
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  wscm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output wscm_pkg::out_t out_data
);
  import wscm_pkg::*;

  q_stat_t q_stat;
  logic    push, pop;
  snap_t   push_data, pop_data;

  // Front: accept strips and accumulate sums.
  wscm_front #(
    .MAX_CLUSTER_STRIPS(MAX_CLUSTER_STRIPS),
    .STRIPS_PER_PLANE  (STRIPS_PER_PLANE)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_stat, .push, .push_data
  );

  // Queue: decouple the two sides.
  wscm_fifo u_fifo (
    .clk, .rst_n, .push, .push_data, .pop, .pop_data, .stat(q_stat)
  );

  // Back: divide, square, root, and hold the result.
  wscm_back u_back (
    .clk, .rst_n, .q_stat, .pop_data, .pop, .out_valid, .out_ready, .out_data
  );

endmodule

[rtl/wscm_fifo.sv]
// ----------------------------------------------------------------------------
// wscm_fifo
// Two-entry queue of cluster snapshots between front and back.
// ----------------------------------------------------------------------------
module wscm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wscm_pkg::snap_t push_data,
  input  logic            pop,
  output wscm_pkg::snap_t pop_data,
  output wscm_pkg::q_stat_t stat
);
  import wscm_pkg::*;

  snap_t       mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign pop_data   = mem_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty)) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
`endif
endmodule

[rtl/wscm_front.sv]
// ----------------------------------------------------------------------------
// wscm_front
// Accepts strips, weights energy and updates the saturating cluster sums.
// ----------------------------------------------------------------------------
module wscm_front #(
  parameter int MAX_CLUSTER_STRIPS = wscm_pkg::DEF_MAX_CLUSTER_STRIPS,
  parameter int STRIPS_PER_PLANE   = wscm_pkg::DEF_STRIPS_PER_PLANE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wscm_pkg::in_t     in_data,
  input  wscm_pkg::q_stat_t q_stat,
  output logic              push,
  output wscm_pkg::snap_t   push_data
);
  import wscm_pkg::*;

  localparam int CW = $clog2(MAX_CLUSTER_STRIPS + 1);
  localparam logic [8:0] IDX_MAX =
    (STRIPS_PER_PLANE > 512) ? 9'd511 : 9'(STRIPS_PER_PLANE - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CLUSTER_STRIPS);

  typedef enum logic [1:0] {F_IDLE, F_ROUND, F_MULT, F_ACC} fstate_t;

  fstate_t           state_r;
  logic              fresh_r, plane_r;
  logic [3:0]        sector_r;
  logic [31:0]       prod_r;
  logic [9:0]        pos_r;
  logic [19:0]       pos2_r;
  logic [17:0]       e_r;
  logic [27:0]       pe_r;
  logic [37:0]       qe_r;
  logic [ESUM_W-1:0] esum_r;
  logic [PSUM_W-1:0] psum_r;
  logic [QSUM_W-1:0] qsum_r;
  logic [CW-1:0]     cnt_r;
  logic              lplane_r, ovf_r;
  logic [3:0]        lsector_r;

  logic [8:0]        idx;
  logic [9:0]        pos;
  logic [32:0]       rnd;
  logic [ESUM_W-1:0] eb;
  logic [PSUM_W-1:0] pb;
  logic [QSUM_W-1:0] qb;
  logic [CW-1:0]     cb;
  logic              ob;
  logic [ESUM_W:0]   es;
  logic [PSUM_W:0]   ps;
  logic [QSUM_W:0]   qs;
  logic [ESUM_W-1:0] esum_nxt;
  logic [PSUM_W-1:0] psum_nxt;
  logic [QSUM_W-1:0] qsum_nxt;
  logic [CW-1:0]     cnt_nxt;
  logic              ovf_nxt, lplane_nxt;
  logic [3:0]        lsector_nxt;
  logic [8:0]        cnt9;

  assign in_ready = (state_r == F_IDLE) && !q_stat.full;
  assign idx = (in_data.strip_index > IDX_MAX) ? IDX_MAX : in_data.strip_index;
  assign pos = {idx, 1'b1};
  assign rnd = {1'b0, prod_r} + 33'd8192;

  always_comb begin
    eb = fresh_r ? '0 : esum_r;
    pb = fresh_r ? '0 : psum_r;
    qb = fresh_r ? '0 : qsum_r;
    cb = fresh_r ? '0 : cnt_r;
    ob = fresh_r ? 1'b0 : ovf_r;
    es = {1'b0, eb} + (ESUM_W+1)'(e_r);
    ps = {1'b0, pb} + (PSUM_W+1)'(pe_r);
    qs = {1'b0, qb} + (QSUM_W+1)'(qe_r);
    esum_nxt    = eb;
    psum_nxt    = pb;
    qsum_nxt    = qb;
    cnt_nxt     = cb;
    ovf_nxt     = ob;
    lplane_nxt  = lplane_r;
    lsector_nxt = lsector_r;
    if (cb >= CNT_MAX) begin
      ovf_nxt = 1'b1;
    end else begin
      if (cb == '0) begin
        lplane_nxt  = plane_r;
        lsector_nxt = sector_r;
      end
      esum_nxt = es[ESUM_W] ? '1 : es[ESUM_W-1:0];
      psum_nxt = ps[PSUM_W] ? '1 : ps[PSUM_W-1:0];
      qsum_nxt = qs[QSUM_W] ? '1 : qs[QSUM_W-1:0];
      cnt_nxt  = cb + 1'b1;
    end
    cnt9 = 9'(cnt_nxt);
    push_data.esum   = esum_nxt;
    push_data.psum   = psum_nxt;
    push_data.qsum   = qsum_nxt;
    push_data.count  = (cnt9 > 9'd127) ? 7'd127 : cnt9[6:0];
    push_data.plane  = lplane_nxt;
    push_data.sector = lsector_nxt;
    push_data.ovf    = ovf_nxt;
  end

  assign push = (state_r == F_ACC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      esum_r    <= '0;
      psum_r    <= '0;
      qsum_r    <= '0;
      cnt_r     <= '0;
      lplane_r  <= 1'b0;
      lsector_r <= 4'd0;
      ovf_r     <= 1'b0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            state_r <= F_ROUND;
          end
        end
        F_ROUND: state_r <= F_MULT;
        F_MULT:  state_r <= F_ACC;
        F_ACC: begin
          state_r   <= F_IDLE;
          esum_r    <= esum_nxt;
          psum_r    <= psum_nxt;
          qsum_r    <= qsum_nxt;
          cnt_r     <= cnt_nxt;
          lplane_r  <= lplane_nxt;
          lsector_r <= lsector_nxt;
          ovf_r     <= ovf_nxt;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid && in_ready) begin
      fresh_r  <= in_data.new_cluster;
      plane_r  <= in_data.strip_plane;
      sector_r <= in_data.strip_sector;
      prod_r   <= in_data.strip_energy * in_data.strip_weight;
      pos_r    <= pos;
      pos2_r   <= pos * pos;
    end
    if (state_r == F_ROUND) begin
      e_r <= rnd[31:14];
    end
    if (state_r == F_MULT) begin
      pe_r <= pos_r * e_r;
      qe_r <= pos2_r * e_r;
    end
  end

endmodule

[rtl/wscm_back.sv]
// ----------------------------------------------------------------------------
// wscm_back
// Divides, squares and takes the square root of a snapshot, one bit a cycle.
// ----------------------------------------------------------------------------
module wscm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  wscm_pkg::q_stat_t q_stat,
  input  wscm_pkg::snap_t   pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output wscm_pkg::out_t    out_data
);
  import wscm_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_MUL, B_SQRT, B_OUT} bstate_t;
  typedef enum logic [1:0] {DV_CEN, DV_A, DV_M} dphase_t;

  bstate_t     state_r;
  dphase_t     phase_r;
  snap_t       snap_r;
  logic [59:0] nq_r;
  logic [23:0] rem_r;
  logic [5:0]  it_r;
  logic [16:0] cen_r;
  logic [59:0] a_r;
  logic [63:0] acc_r, mcand_r;
  logic [49:0] mplier_r;
  logic [63:0] v_r;
  logic [31:0] root_r;
  logic [33:0] srem_r;
  logic [16:0] rms_r;
  out_t        out_r;
  logic        out_valid_r;

  logic [24:0] dt;
  logic        dge;
  logic [63:0] bsum;
  logic [59:0] bval;
  logic [33:0] st, trial;
  logic        sge;

  assign dt  = {rem_r, nq_r[59]};
  assign dge = dt >= {1'b0, snap_r.esum};
  assign bsum = acc_r + 64'd32768;
  assign bval = {12'd0, bsum[63:16]};
  assign st    = {srem_r[31:0], v_r[63:62]};
  assign trial = {root_r, 2'b01};
  assign sge   = st >= trial;

  assign pop = (state_r == B_IDLE) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      phase_r     <= DV_CEN;
      it_r        <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (pop) begin
            state_r <= (pop_data.esum == '0) ? B_OUT : B_DIV;
            phase_r <= DV_CEN;
            it_r    <= 6'd0;
          end
        end
        B_DIV: begin
          it_r <= it_r + 6'd1;
          if (it_r == 6'd59) begin
            it_r <= 6'd0;
            case (phase_r)
              DV_CEN:  phase_r <= DV_A;
              DV_A:    phase_r <= DV_M;
              DV_M:    state_r <= B_MUL;
              default: phase_r <= DV_CEN;
            endcase
          end
        end
        B_MUL: begin
          it_r <= it_r + 6'd1;
          if (it_r == 6'd49) begin
            it_r    <= 6'd0;
            state_r <= B_SQRT;
          end
        end
        B_SQRT: begin
          it_r <= it_r + 6'd1;
          if (it_r == 6'd31) begin
            it_r    <= 6'd0;
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        snap_r <= pop_data;
        cen_r  <= '0;
        rms_r  <= '0;
        rem_r  <= '0;
        nq_r   <= {pop_data.psum, 7'd0} + 60'(pop_data.esum[23:1]);
      end
      B_DIV: begin
        rem_r <= dge ? 24'(dt - {1'b0, snap_r.esum}) : dt[23:0];
        nq_r  <= {nq_r[58:0], dge};
        if (it_r == 6'd59) begin
          rem_r <= '0;
          case (phase_r)
            DV_CEN: begin
              cen_r <= ({nq_r[58:0], dge} > 60'd131071) ? 17'h1FFFF :
                       nq_r[15:0] == 16'd0 && 1'b0 ? 17'd0 : {nq_r[15:0], dge};
              nq_r  <= {snap_r.qsum, 14'd0};
            end
            DV_A: begin
              a_r  <= {nq_r[58:0], dge};
              nq_r <= {10'd0, snap_r.psum, 15'd0};
            end
            default: begin
              acc_r    <= '0;
              mcand_r  <= {14'd0, nq_r[48:0], dge};
              mplier_r <= {nq_r[48:0], dge};
            end
          endcase
        end
      end
      B_MUL: begin
        acc_r    <= acc_r + (mplier_r[0] ? mcand_r : 64'd0);
        mcand_r  <= {mcand_r[62:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[49:1]};
        v_r      <= '0;
        root_r   <= '0;
        srem_r   <= '0;
      end
      B_SQRT: begin
        if (it_r == 6'd0) begin
          // Load the clamped variance one bit pair up, so the 31 root steps
          // that follow consume every pair of its 60 bits.
          v_r    <= {2'd0, (a_r > bval) ? (a_r - bval) : 60'd0, 2'd0};
          root_r <= '0;
          srem_r <= '0;
        end else begin
          srem_r <= sge ? (st - trial) : st;
          root_r <= {root_r[30:0], sge};
          v_r    <= {v_r[61:0], 2'b00};
        end
      end
      B_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_r.cluster_energy    <= snap_r.esum;
          out_r.centroid          <= cen_r;
          out_r.rms_width         <= rms_r;
          out_r.strips_in_cluster <= snap_r.count;
          out_r.seed_plane        <= snap_r.plane;
          out_r.seed_sector       <= snap_r.sector;
          out_r.zero_energy       <= (snap_r.esum == '0);
          out_r.overflow          <= snap_r.ovf;
        end
      end
      default: ;
    endcase
    if (state_r == B_SQRT && it_r == 6'd31) begin
      rms_r <= ({root_r[30:0], sge} > 32'd131071) ? 17'h1FFFF :
               {root_r[15:0], sge};
    end
  end

`ifndef SYNTHESIS
  a_zero_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.zero_energy) |-> (out_r.centroid == '0 && out_r.rms_width == '0))
    else $error("zero energy with nonzero moments");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == B_IDLE) else $error("pop while busy");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == B_OUT) else $error("result without work");
`endif
endmodule
